[rtl/serial_line_editor_top_macros.svh]
// assertion macros for the line editor
`ifndef SERIAL_LINE_EDITOR_TOP_MACROS_SVH
`define SERIAL_LINE_EDITOR_TOP_MACROS_SVH
// assert that an implication holds at every clock unless in reset
`define SLE_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// assert that a condition holds in the cycle after another
`define SLE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

[rtl/sle_pkg.sv]
// shared types and constants of the line editor
package sle_pkg;
   localparam int LINE_MAX_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CH_ESC = 8'h1B;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_DEL = 8'h7F;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_C = 8'h43;
   localparam logic [7:0] CH_D = 8'h44;
   localparam logic [7:0] CH_THREE = 8'h33;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_S = 8'h73;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_F = 8'h46;
   localparam logic [7:0] CH_E = 8'h45;
   localparam logic [7:0] CH_K = 8'h4B;
   localparam logic [7:0] CH_U = 8'h75;

   // command classes passed from front to back
   typedef enum logic [2:0] {
      CMD_INSERT,
      CMD_ENTER,
      CMD_BACKSPACE,
      CMD_DELETE,
      CMD_LEFT,
      CMD_RIGHT,
      CMD_NONE
   } cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic [7:0] data;
   } cmd_item_type;
endpackage

[rtl/sle_ram.sv]
// generic ram with one write port and one registered read port
module sle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input logic clock,
   input logic wr_en,
   input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/sle_front.sv]
// byte classifier: escape sequence decode and command queue
module sle_front (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [7:0] req_rx_byte,
   output logic cmd_valid,
   input logic cmd_ready,
   output sle_pkg::cmd_item_type cmd_item
);
   import sle_pkg::*;

   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ESC,
      PH_BRACKET,
      PH_THREE
   } phase_type;

   phase_type phase_ff, phase_in;
   cmd_item_type q_ff [QUEUE_DEPTH];
   cmd_item_type q_in [QUEUE_DEPTH];
   logic [$clog2(QUEUE_DEPTH+1)-1:0] cnt_ff, cnt_in;
   cmd_item_type cls;
   logic push, pop;

   assign req_ready = cnt_ff != QUEUE_DEPTH[$clog2(QUEUE_DEPTH+1)-1:0];
   assign cmd_valid = cnt_ff != '0;
   assign cmd_item = q_ff[0];

   always_comb begin
      phase_in = phase_ff;
      cls.cmd = CMD_NONE;
      cls.data = req_rx_byte;
      unique case (phase_ff)
         PH_IDLE: begin
            if (req_rx_byte == CH_ESC) begin
               phase_in = PH_ESC;
            end else if (req_rx_byte == CH_CR) begin
               cls.cmd = CMD_ENTER;
            end else if (req_rx_byte == CH_DEL) begin
               cls.cmd = CMD_BACKSPACE;
            end else if (req_rx_byte >= CH_SPACE && req_rx_byte < CH_DEL) begin
               cls.cmd = CMD_INSERT;
            end
         end
         PH_ESC: begin
            if (req_rx_byte == CH_LBRACKET) begin
               phase_in = PH_BRACKET;
            end else if (req_rx_byte != CH_ESC) begin
               phase_in = PH_IDLE;
            end
         end
         PH_BRACKET: begin
            phase_in = PH_IDLE;
            if (req_rx_byte == CH_C) begin
               cls.cmd = CMD_RIGHT;
            end else if (req_rx_byte == CH_D) begin
               cls.cmd = CMD_LEFT;
            end else if (req_rx_byte == CH_THREE) begin
               phase_in = PH_THREE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (req_rx_byte == CH_TILDE) begin
               cls.cmd = CMD_DELETE;
            end
         end
      endcase
   end

   // bytes that cause nothing never enter the queue
   assign push = req_valid && req_ready && cls.cmd != CMD_NONE;
   assign pop = cmd_valid && cmd_ready;

   always_comb begin
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            q_in[i] = q_ff[i+1];
         end
      end
      if (push) begin
         q_in[QAW'(cnt_ff - {{($clog2(QUEUE_DEPTH+1)-1){1'b0}}, pop})] = cls;
      end
      cnt_in = cnt_ff + {{($clog2(QUEUE_DEPTH+1)-1){1'b0}}, push}
         - {{($clog2(QUEUE_DEPTH+1)-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff <= '0;
      end else begin
         if (req_valid && req_ready) begin
            phase_ff <= phase_in;
         end
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end
endmodule

[rtl/sle_back.sv]
// command executor: line store edits and echo byte sequencing
module sle_back #(
   parameter int LINE_MAX = sle_pkg::LINE_MAX_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic [5:0] line_limit,
   input logic cmd_valid,
   output logic cmd_ready,
   input sle_pkg::cmd_item_type cmd_item,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic rsp_out_kind,
   output logic rsp_line_done,
   output logic [5:0] rsp_line_length,
   output logic rsp_last_of_run
);
   import sle_pkg::*;
   `include "serial_line_editor_top_macros.svh"

   localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
   localparam logic [5:0] MAX6 = 6'(LINE_MAX);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PRE,
      ST_BODY_RD,
      ST_BODY,
      ST_POST,
      ST_ENTER_HD,
      ST_ENTER_RD,
      ST_ENTER_BODY,
      ST_SINGLE
   } state_type;

   state_type state_ff;
   cmd_item_type cmd_ff;
   logic [5:0] cur_ff, len_ff, idx_ff, enlen_ff;
   logic [3:0] sub_ff;
   logic [1:0] tail_ff;
   logic out_full_ff;
   logic [7:0] o_byte_ff;
   logic o_kind_ff, o_done_ff, o_last_ff;
   logic [5:0] o_len_ff;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0] wr_data, rd_data;
   logic [5:0] lim;
   logic emit_ok;

   sle_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign lim = (line_limit > MAX6) ? MAX6 : line_limit;
   assign emit_ok = !out_full_ff || rsp_ready;
   assign cmd_ready = state_ff == ST_IDLE;

   assign rsp_valid = out_full_ff;
   assign rsp_out_byte = o_byte_ff;
   assign rsp_out_kind = o_kind_ff;
   assign rsp_line_done = o_done_ff;
   assign rsp_line_length = o_len_ff;
   assign rsp_last_of_run = o_last_ff;

   // prefix ESC[s ESC[0F ESC[0E ESC[K, 14 bytes
   function automatic logic [7:0] pre_byte(input logic [3:0] k);
      logic [7:0] b;
      unique case (k)
         4'd0, 4'd3, 4'd7, 4'd11: b = CH_ESC;
         4'd1, 4'd4, 4'd8, 4'd12: b = CH_LBRACKET;
         4'd2: b = CH_S;
         4'd5, 4'd9: b = CH_ZERO;
         4'd6: b = CH_F;
         4'd10: b = CH_E;
         default: b = CH_K;
      endcase
      return b;
   endfunction

   // per-state memory control
   always_comb begin
      wr_en = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rd_data;
      rd_addr = idx_ff[AW-1:0];
      if (state_ff == ST_IDLE && cmd_valid && cmd_item.cmd == CMD_INSERT
          && len_ff < lim && cur_ff >= len_ff) begin
         wr_en = 1'b1;
         wr_addr = len_ff[AW-1:0];
         wr_data = cmd_item.data;
      end else if (state_ff == ST_SHIFT_RD) begin
         // insert reads idx-1, removal reads idx+1
         rd_addr = (cmd_ff.cmd == CMD_INSERT) ? AW'(idx_ff - 6'd1) : AW'(idx_ff + 6'd1);
      end else if (state_ff == ST_SHIFT_WR) begin
         wr_en = 1'b1;
         if (cmd_ff.cmd == CMD_INSERT && idx_ff == cur_ff) begin
            wr_data = cmd_ff.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cur_ff <= '0;
         len_ff <= '0;
         out_full_ff <= 1'b0;
      end else begin
         if (out_full_ff && rsp_ready) begin
            out_full_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff <= cmd_item;
                  sub_ff <= '0;
                  unique case (cmd_item.cmd)
                     CMD_INSERT: begin
                        if (len_ff < lim) begin
                           if (cur_ff < len_ff) begin
                              idx_ff <= len_ff;
                              len_ff <= len_ff + 6'd1;
                              tail_ff <= 2'd1;
                              state_ff <= ST_SHIFT_RD;
                           end else begin
                              len_ff <= len_ff + 6'd1;
                              cur_ff <= len_ff + 6'd1;
                              state_ff <= ST_SINGLE;
                           end
                        end
                     end
                     CMD_ENTER: begin
                        enlen_ff <= len_ff;
                        idx_ff <= '0;
                        state_ff <= ST_ENTER_HD;
                     end
                     CMD_BACKSPACE: begin
                        if (cur_ff != '0) begin
                           cur_ff <= cur_ff - 6'd1;
                           idx_ff <= cur_ff - 6'd1;
                           tail_ff <= 2'd2;
                           state_ff <= ST_SHIFT_RD;
                        end
                     end
                     CMD_DELETE: begin
                        if (cur_ff < len_ff) begin
                           idx_ff <= cur_ff;
                           tail_ff <= 2'd0;
                           state_ff <= ST_SHIFT_RD;
                        end
                     end
                     CMD_LEFT: begin
                        if (cur_ff != '0) begin
                           cur_ff <= cur_ff - 6'd1;
                           state_ff <= ST_POST;
                           sub_ff <= 4'd2;
                           tail_ff <= 2'd2;
                        end
                     end
                     CMD_RIGHT: begin
                        if (cur_ff < len_ff) begin
                           cur_ff <= cur_ff + 6'd1;
                           state_ff <= ST_POST;
                           sub_ff <= 4'd2;
                           tail_ff <= 2'd1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SHIFT_RD: begin
               if (cmd_ff.cmd == CMD_INSERT) begin
                  if (idx_ff == cur_ff) begin
                     state_ff <= ST_SHIFT_WR;
                  end else begin
                     state_ff <= ST_SHIFT_WR;
                  end
               end else if (idx_ff + 6'd1 >= len_ff) begin
                  len_ff <= len_ff - 6'd1;
                  state_ff <= ST_PRE;
               end else begin
                  state_ff <= ST_SHIFT_WR;
               end
            end
            ST_SHIFT_WR: begin
               if (cmd_ff.cmd == CMD_INSERT) begin
                  if (idx_ff == cur_ff) begin
                     cur_ff <= cur_ff + 6'd1;
                     state_ff <= ST_PRE;
                  end else begin
                     idx_ff <= idx_ff - 6'd1;
                     state_ff <= ST_SHIFT_RD;
                  end
               end else begin
                  idx_ff <= idx_ff + 6'd1;
                  state_ff <= ST_SHIFT_RD;
               end
            end
            ST_PRE: begin
               if (emit_ok) begin
                  o_byte_ff <= pre_byte(sub_ff);
                  o_kind_ff <= 1'b0;
                  o_done_ff <= 1'b0;
                  o_len_ff <= '0;
                  o_last_ff <= 1'b0;
                  out_full_ff <= 1'b1;
                  if (sub_ff == 4'd13) begin
                     idx_ff <= '0;
                     sub_ff <= '0;
                     state_ff <= (len_ff == '0) ? ST_POST : ST_BODY_RD;
                  end else begin
                     sub_ff <= sub_ff + 4'd1;
                  end
               end
            end
            ST_BODY_RD: begin
               state_ff <= ST_BODY;
            end
            ST_BODY: begin
               if (emit_ok) begin
                  o_byte_ff <= rd_data;
                  o_last_ff <= 1'b0;
                  out_full_ff <= 1'b1;
                  idx_ff <= idx_ff + 6'd1;
                  state_ff <= (idx_ff + 6'd1 >= len_ff) ? ST_POST : ST_BODY_RD;
               end
            end
            ST_POST: begin
               // ESC[u then optional ESC[C / ESC[D; sub 2.. is tail only
               if (emit_ok) begin
                  o_kind_ff <= 1'b0;
                  o_done_ff <= 1'b0;
                  o_len_ff <= '0;
                  out_full_ff <= 1'b1;
                  unique case (sub_ff)
                     4'd0, 4'd3: o_byte_ff <= CH_ESC;
                     4'd1, 4'd4: o_byte_ff <= CH_LBRACKET;
                     4'd2: o_byte_ff <= CH_U;
                     default: o_byte_ff <= (tail_ff == 2'd1) ? CH_C : CH_D;
                  endcase
                  if (sub_ff == 4'd2 && cmd_ff.cmd != CMD_LEFT
                      && cmd_ff.cmd != CMD_RIGHT) begin
                     o_byte_ff <= CH_U;
                  end else if (sub_ff == 4'd2) begin
                     o_byte_ff <= CH_ESC;
                  end
                  if ((sub_ff == 4'd2 && tail_ff == 2'd0) || sub_ff == 4'd5) begin
                     o_last_ff <= 1'b1;
                     state_ff <= ST_IDLE;
                  end else begin
                     o_last_ff <= 1'b0;
                     sub_ff <= (sub_ff == 4'd2 && (cmd_ff.cmd == CMD_LEFT
                        || cmd_ff.cmd == CMD_RIGHT)) ? 4'd4 : sub_ff + 4'd1;
                  end
               end
            end
            ST_ENTER_HD: begin
               if (emit_ok) begin
                  o_kind_ff <= 1'b0;
                  o_done_ff <= 1'b1;
                  o_len_ff <= enlen_ff;
                  out_full_ff <= 1'b1;
                  o_byte_ff <= (sub_ff == '0) ? CH_CR : CH_LF;
                  o_last_ff <= sub_ff != '0 && enlen_ff == '0;
                  if (sub_ff != '0) begin
                     len_ff <= '0;
                     cur_ff <= '0;
                     state_ff <= (enlen_ff == '0) ? ST_IDLE : ST_ENTER_RD;
                  end
                  sub_ff <= 4'd1;
               end
            end
            ST_ENTER_RD: begin
               state_ff <= ST_ENTER_BODY;
            end
            default: begin
               if (state_ff == ST_SINGLE) begin
                  if (emit_ok) begin
                     o_byte_ff <= cmd_ff.data;
                     o_kind_ff <= 1'b0;
                     o_done_ff <= 1'b0;
                     o_len_ff <= '0;
                     o_last_ff <= 1'b1;
                     out_full_ff <= 1'b1;
                     state_ff <= ST_IDLE;
                  end
               end else if (emit_ok) begin
                  o_byte_ff <= rd_data;
                  o_kind_ff <= 1'b1;
                  o_done_ff <= 1'b1;
                  o_len_ff <= enlen_ff;
                  o_last_ff <= idx_ff + 6'd1 >= enlen_ff;
                  out_full_ff <= 1'b1;
                  idx_ff <= idx_ff + 6'd1;
                  state_ff <= (idx_ff + 6'd1 >= enlen_ff) ? ST_IDLE : ST_ENTER_RD;
               end
            end
         endcase
      end
   end

   `SLE_ASSERT_IMP(a_cur_in_line, clock, reset, 1'b1, cur_ff <= len_ff || state_ff != ST_IDLE)
   `SLE_ASSERT_IMP(a_len_limit, clock, reset, 1'b1, len_ff <= MAX6)
   `SLE_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_byte))
endmodule

[rtl/serial_line_editor_top.sv]
// top level of the serial line editor
//  channel | direction | handshake
//  req     | in        | req_valid / req_ready, req_rx_byte
//  rsp     | out       | rsp_valid / rsp_ready, five result fields
//  csr     | in        | csr_write_enable / csr_write_data, no wait
// a plain insert at the end of the line is echoed via the command queue, state ST_SINGLE and the output register
// a redraw shifts the stored bytes, then sends a 14 byte prefix, the line bytes and a 3 to 6 byte tail
// worst case is an insert at column 0 of a 31 byte line
// rate is set by the single read port of the line store
// synchronous reset clears cursor, length and escape phase, line limit to 32
// a two entry command queue lets the decoder run while output is stalled
module serial_line_editor_top #(
   parameter int LINE_MAX = sle_pkg::LINE_MAX_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [7:0] req_rx_byte,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic rsp_out_kind,
   output logic rsp_line_done,
   output logic [5:0] rsp_line_length,
   output logic rsp_last_of_run,
   input logic csr_write_enable,
   input logic [5:0] csr_write_data
);
   import sle_pkg::*;

   logic [5:0] limit_ff;
   logic cmd_valid, cmd_ready;
   cmd_item_type cmd_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 6'd32;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   sle_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_rx_byte(req_rx_byte), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
      .cmd_item(cmd_item)
   );

   sle_back #(.LINE_MAX(LINE_MAX)) u_back (
      .clock(clock), .reset(reset), .line_limit(limit_ff), .cmd_valid(cmd_valid),
      .cmd_ready(cmd_ready), .cmd_item(cmd_item), .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready), .rsp_out_byte(rsp_out_byte), .rsp_out_kind(rsp_out_kind),
      .rsp_line_done(rsp_line_done), .rsp_line_length(rsp_line_length),
      .rsp_last_of_run(rsp_last_of_run)
   );
endmodule

[dv/tb_top.sv]
// self-checking testbench for the serial line editor
`timescale 1ns / 100ps

module tb_top;
   import sle_pkg::*;

   localparam int LMAX = 32;
   localparam int LIMIT_CYCLES = 2000000;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_kind;
      logic       line_done;
      logic [5:0] line_length;
      logic       last_of_run;
   } echo_rec;

   typedef struct {
      logic [7:0] rx;
      int         fixed_cnt;   // -1: use predictor only
      logic [7:0] fixed_byte;
   } stim_row;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic rsp_out_kind;
   logic rsp_line_done;
   logic [5:0] rsp_line_length;
   logic rsp_last_of_run;
   logic csr_write_enable = 1'b0;
   logic [5:0] csr_write_data = 6'd0;

   // predictor state
   logic [7:0] ed_line[LMAX];
   int ed_cursor, ed_len, ed_phase, ed_limit;
   echo_rec echo_q[$];
   int errors = 0;
   longint cycles = 0;
   int last_cnt = 0;
   logic [7:0] last_first = 8'h00;

   serial_line_editor_top dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout at %0t", $time);
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic void emit(logic [7:0] b, logic k, logic d, logic [5:0] l);
      echo_rec r;
      r.out_byte = b;
      r.out_kind = k;
      r.line_done = d;
      r.line_length = l;
      r.last_of_run = 1'b0;
      echo_q.push_back(r);
   endfunction

   function automatic void emit_echo(logic [7:0] b);
      emit(b, 1'b0, 1'b0, 6'd0);
   endfunction

   function automatic void emit_csi(logic [7:0] c);
      emit_echo(CH_ESC);
      emit_echo(CH_LBRACKET);
      emit_echo(c);
   endfunction

   function automatic void emit_redraw(int tail);   // 0 none, 1 right, 2 left
      emit_csi(CH_S);
      emit_csi(CH_ZERO);
      emit_echo(CH_F);
      emit_csi(CH_ZERO);
      emit_echo(CH_E);
      emit_csi(CH_K);
      for (int i = 0; i < ed_len; i++) emit_echo(ed_line[i]);
      emit_csi(CH_U);
      if (tail == 1) emit_csi(CH_C);
      if (tail == 2) emit_csi(CH_D);
   endfunction

   function automatic void drop_char(int pos);
      for (int i = pos; i + 1 < ed_len; i++) ed_line[i] = ed_line[i + 1];
      ed_len--;
   endfunction

   // returns number of results produced by this byte
   function automatic int edit_byte(logic [7:0] b);
      int before_cnt;
      int lim;
      before_cnt = echo_q.size();
      lim = (ed_limit > LMAX) ? LMAX : ed_limit;
      unique case (ed_phase)
         0: begin
            if (b == CH_ESC) ed_phase = 1;
            else if (b == CH_CR) begin
               emit(CH_CR, 1'b0, 1'b1, ed_len[5:0]);
               emit(CH_LF, 1'b0, 1'b1, ed_len[5:0]);
               for (int i = 0; i < ed_len; i++) emit(ed_line[i], 1'b1, 1'b1, ed_len[5:0]);
               ed_len = 0;
               ed_cursor = 0;
            end else if (b == CH_DEL) begin
               if (ed_cursor > 0) begin
                  ed_cursor--;
                  drop_char(ed_cursor);
                  emit_redraw(2);
               end
            end else if (b >= CH_SPACE && b <= CH_TILDE && ed_len < lim) begin
               if (ed_cursor < ed_len) begin
                  for (int i = ed_len; i > ed_cursor; i--) ed_line[i] = ed_line[i - 1];
                  ed_line[ed_cursor] = b;
                  ed_cursor++;
                  ed_len++;
                  emit_redraw(1);
               end else begin
                  ed_line[ed_len] = b;
                  ed_len++;
                  ed_cursor = ed_len;
                  emit_echo(b);
               end
            end
         end
         1: ed_phase = (b == CH_LBRACKET) ? 2 : (b == CH_ESC) ? 1 : 0;
         2: begin
            ed_phase = 0;
            if (b == CH_C && ed_cursor < ed_len) begin
               emit_csi(CH_C);
               ed_cursor++;
            end else if (b == CH_D && ed_cursor > 0) begin
               emit_csi(CH_D);
               ed_cursor--;
            end else if (b == CH_THREE) ed_phase = 3;
         end
         default: begin
            ed_phase = 0;
            if (b == CH_TILDE && ed_cursor < ed_len) begin
               drop_char(ed_cursor);
               emit_redraw(0);
            end
         end
      endcase
      if (echo_q.size() > before_cnt) echo_q[echo_q.size() - 1].last_of_run = 1'b1;
      return echo_q.size() - before_cnt;
   endfunction

   task automatic wait_cycles(int n);
      repeat (n) @(negedge clock);
   endtask

   // valid stays high into the next byte when no idle cycles are drawn
   task automatic send_byte(logic [7:0] b);
      int idle;
      idle = $urandom_range(0, 4);
      if (idle != 0) begin
         req_valid <= 1'b0;
         wait_cycles(idle);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      last_cnt = edit_byte(b);
      last_first = (last_cnt > 0) ? echo_q[echo_q.size() - last_cnt].out_byte : 8'h00;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (echo_q.size() != 0) @(negedge clock);
      wait_cycles(150);   // a dropped or silent byte may still be in the pipe
   endtask

   task automatic set_limit(int v);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data <= v[5:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      ed_limit = v;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_key(int k);
      unique case (k)
         0: send_byte(CH_DEL);
         1: begin
            send_byte(CH_ESC); send_byte(CH_LBRACKET); send_byte(CH_C);
         end
         2: begin
            send_byte(CH_ESC); send_byte(CH_LBRACKET); send_byte(CH_D);
         end
         3: begin
            send_byte(CH_ESC); send_byte(CH_LBRACKET); send_byte(CH_THREE);
            send_byte(CH_TILDE);
         end
         4: begin
            send_byte(CH_ESC); send_byte(CH_LBRACKET); send_byte(8'h41);
         end
         default: send_byte(CH_CR);
      endcase
   endtask

   // result side: random idle cycles per transfer, compare at rising edge
   initial begin
      int gap;
      echo_rec e;
      echo_rec a;
      @(negedge clock);
      forever begin
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            wait_cycles(gap);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (reset || !rsp_valid);
         if (echo_q.size() == 0) begin
            $display("%0t unexpected transfer: expected none actual byte %h",
               $time, rsp_out_byte);
            errors++;
         end else begin
            e = echo_q.pop_front();
            a = '{rsp_out_byte, rsp_out_kind, rsp_line_done, rsp_line_length,
                  rsp_last_of_run};
            if (a !== e) begin
               $display("%0t mismatch: expected %h/%b/%b/%0d/%b actual %h/%b/%b/%0d/%b",
                  $time, e.out_byte, e.out_kind, e.line_done, e.line_length,
                  e.last_of_run, a.out_byte, a.out_kind, a.line_done, a.line_length,
                  a.last_of_run);
               errors++;
            end
         end
         @(negedge clock);
      end
   end

   stim_row dir_rows[24] = '{
      '{8'h7F, 0, 8'h00},        // backspace on empty line
      '{8'h41, 1, 8'h41},
      '{8'h20, 1, 8'h20},
      '{8'h7E, 1, 8'h7E},
      '{8'h5B, 1, 8'h5B},        // lone bracket is printable
      '{8'h00, 0, 8'h00},
      '{8'hFF, 0, 8'h00},
      '{8'h80, 0, 8'h00},
      '{8'h1B, 0, 8'h00},
      '{8'h5B, 0, 8'h00},
      '{8'h44, -1, 8'h00},       // left
      '{8'h62, -1, 8'h00},       // mid-line insert
      '{8'h1B, 0, 8'h00},
      '{8'h5B, 0, 8'h00},
      '{8'h33, 0, 8'h00},
      '{8'h7E, -1, 8'h00},       // delete
      '{8'h1B, 0, 8'h00},
      '{8'h1B, 0, 8'h00},        // esc restarts
      '{8'h0D, 0, 8'h00},        // aborts sequence
      '{8'h7F, -1, 8'h00},
      '{8'h1B, 0, 8'h00},
      '{8'h5B, 0, 8'h00},
      '{8'h42, 0, 8'h00},        // down does nothing
      '{8'h0D, -1, 8'h00}
   };

   initial begin
      ed_cursor = 0; ed_len = 0; ed_phase = 0; ed_limit = 32;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) begin
         send_byte(dir_rows[i].rx);
         if (dir_rows[i].fixed_cnt >= 0) begin
            if (last_cnt != dir_rows[i].fixed_cnt
                || (last_cnt == 1 && last_first != dir_rows[i].fixed_byte)) begin
               $display("%0t table row %0d: expected %0d results %h actual %0d results %h",
                  $time, i, dir_rows[i].fixed_cnt, dir_rows[i].fixed_byte, last_cnt,
                  last_first);
               errors++;
            end
         end
      end
      // fill past the limits, extremes 1 and 32, then 0 and 63
      set_limit(1);
      send_text("xyz"); send_key(2); send_text("q"); send_key(5);
      set_limit(32);
      for (int i = 0; i < 34; i++) send_byte(8'(8'h21 + i));
      send_key(2); send_key(2); send_byte(8'h61); send_key(5);
      set_limit(0);
      send_text("ab"); send_key(5);
      set_limit(63);
      // random: editing sessions, with some noise
      for (int it = 0; it < 175;) begin
         int r;
         if (it == 80) set_limit(int'($urandom_range(3, 12)));
         if (it == 130) set_limit(32);
         if (it == 40) wait_idle();
         r = $urandom_range(0, 19);
         if (r < 9) send_byte(8'($urandom_range(8'h20, 8'h7E)));
         else if (r < 16) send_key(int'($urandom_range(0, 4)));
         else if (r < 17) send_byte(CH_CR);
         else if (r < 18) send_byte(8'($urandom_range(0, 255)));
         else begin
            send_byte(CH_ESC);
            send_byte(8'($urandom_range(0, 255)));
         end
         it++;
      end
      send_byte(CH_CR);
      wait_idle();
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule

[serial_line_editor_top.f]
+incdir+rtl
rtl/sle_pkg.sv
rtl/sle_ram.sv
rtl/sle_front.sv
rtl/sle_back.sv
rtl/serial_line_editor_top.sv
dv/tb_top.sv
